[rtl/clnw_pkg.sv]
package clnw_pkg;

  // request codes
  typedef enum logic [2:0] {
    MODE_INIT    = 3'd0,
    MODE_COMMAND = 3'd1,
    MODE_DATA    = 3'd2,
    MODE_CLEAR   = 3'd3,
    MODE_HOME    = 3'd4,
    MODE_CURSOR  = 3'd5
  } mode_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE3_ADDR  = 4'd0,
    CFG_LINE4_ADDR  = 4'd1,
    CFG_EN_PULSE    = 4'd2,
    CFG_CMD_WAIT    = 4'd3,
    CFG_DATA_WAIT   = 4'd4,
    CFG_LONG_WAIT   = 4'd5,
    CFG_BOOTUP_WAIT = 4'd6,
    CFG_RESET_WAIT  = 4'd7
  } cfg_idx_e;

  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned HOLD_W     = 20;

  // which wait closes the final byte of a job
  typedef enum logic [1:0] {
    WAIT_CMD,
    WAIT_DATA,
    WAIT_LONG
  } wait_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] value;
    logic [2:0] row;
    logic [6:0] column;
  } in_item_t;

  typedef struct packed {
    logic              reg_select;
    logic              enable;
    logic [3:0]        nibble;
    logic [HOLD_W-1:0] hold_us;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  line3_address;
    logic [6:0]  line4_address;
    logic [15:0] enable_pulse_us;
    logic [15:0] command_wait_us;
    logic [15:0] data_wait_us;
    logic [19:0] long_wait_us;
    logic [19:0] bootup_wait_us;
    logic [19:0] reset_wait_us;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    line3_address:   7'd16,
    line4_address:   7'd80,
    enable_pulse_us: 16'd20,
    command_wait_us: 16'd42,
    data_wait_us:    16'd46,
    long_wait_us:    20'd2000,
    bootup_wait_us:  20'd15000,
    reset_wait_us:   20'd5000
  };

  // job handed from front to back
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] byte_val;
    wait_e      wait_sel;
  } job_t;

  localparam int unsigned QDEPTH = 4;

  // pin-state step numbering of a full init run
  localparam int unsigned STEP_W     = 5;
  localparam logic [STEP_W-1:0] STEP_BYTES0 = 5'd9;
  localparam logic [STEP_W-1:0] STEP_BYTE   = 5'd21;
  localparam logic [STEP_W-1:0] STEP_LAST   = 5'd24;

  localparam logic [HOLD_W-1:0] SHORT_RESET_US = 20'd1000;

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_DISPLAY  = 8'h0C;
  localparam logic [7:0] CMD_FUNCTION = 8'h28;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [6:0] ROW2_START   = 7'h40;

  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = CMD_FUNCTION;
      2'd1:    b = CMD_DISPLAY;
      2'd2:    b = CMD_ENTRY;
      default: b = CMD_CLEAR;
    endcase
    return b;
  endfunction

endpackage

[rtl/char_lcd_nibble_writer_core.sv]
// channel | direction | handshake             | payload
// --------+-----------+-----------------------+------------------------------
// in      | input     | in_valid_i/in_ready_o | in_data_i  (in_item_t)
// out     | output    | out_valid_o/out_ready_i | out_data_o (out_item_t)
// cfg     | input     | cfg_we_i, no wait     | cfg_idx_i, cfg_data_i
//
// an init request gives 25 pin states (steps 0 to 24), any byte request 4;
// the back sequencer emits one pin state per cycle into its output register while
// the output is not stalled, and fetches each job in its idle state
// requests that produce nothing are taken and dropped by the front
// reset clears the queue and the sequencer and puts the registers to defaults
// a stalled output holds the sequencer; the queue keeps taking requests until full
module char_lcd_nibble_writer_core
  import clnw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;

  // front to queue
  logic q_push;
  job_t q_push_job;
  logic q_full;
  // queue to back
  logic q_pop;
  job_t q_pop_job;
  logic q_empty;

  // register file, each register keeps only its own width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LINE3_ADDR:  cfg_q.line3_address   <= cfg_data_i[6:0];
        CFG_LINE4_ADDR:  cfg_q.line4_address   <= cfg_data_i[6:0];
        CFG_EN_PULSE:    cfg_q.enable_pulse_us <= cfg_data_i[15:0];
        CFG_CMD_WAIT:    cfg_q.command_wait_us <= cfg_data_i[15:0];
        CFG_DATA_WAIT:   cfg_q.data_wait_us    <= cfg_data_i[15:0];
        CFG_LONG_WAIT:   cfg_q.long_wait_us    <= cfg_data_i[19:0];
        CFG_BOOTUP_WAIT: cfg_q.bootup_wait_us  <= cfg_data_i[19:0];
        CFG_RESET_WAIT:  cfg_q.reset_wait_us   <= cfg_data_i[19:0];
        default: ;  // indexes past the list are ignored
      endcase
    end
  end

  // classification and cursor address
  clnw_front u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_data_i       (in_data_i),
    .line3_address_i (cfg_q.line3_address),
    .line4_address_i (cfg_q.line4_address),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_job_o         (q_push_job)
  );

  // short job queue decoupling the two sides
  clnw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_job),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_job),
    .empty_o     (q_empty)
  );

  // pin-state sequencer with output register
  clnw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_job_i     (q_pop_job),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/clnw_front.sv]
module clnw_front
  import clnw_pkg::*;
(
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  input  logic [6:0] line3_address_i,
  input  logic [6:0] line4_address_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output job_t       q_job_o
);

  logic       keep;
  logic [6:0] row_start;
  logic [6:0] ddram_addr;

  assign in_ready_o = !q_full_i;

  always_comb begin
    row_start = '0;
    unique case (in_data_i.row)
      3'd1:    row_start = '0;
      3'd2:    row_start = ROW2_START;
      3'd3:    row_start = line3_address_i;
      3'd4:    row_start = line4_address_i;
      default: row_start = '0;
    endcase
  end

  // address wraps within the 7-bit display ram space
  assign ddram_addr = row_start + in_data_i.column;

  always_comb begin
    keep             = 1'b1;
    q_job_o.is_init  = 1'b0;
    q_job_o.rs       = 1'b0;
    q_job_o.byte_val = in_data_i.value;
    q_job_o.wait_sel = WAIT_CMD;
    unique case (in_data_i.mode)
      MODE_INIT: begin
        q_job_o.is_init  = 1'b1;
        q_job_o.byte_val = CMD_CLEAR;
        q_job_o.wait_sel = WAIT_LONG;
      end
      MODE_COMMAND: q_job_o.wait_sel = WAIT_CMD;
      MODE_DATA: begin
        q_job_o.rs       = 1'b1;
        q_job_o.wait_sel = WAIT_DATA;
      end
      MODE_CLEAR: begin
        q_job_o.byte_val = CMD_CLEAR;
        q_job_o.wait_sel = WAIT_LONG;
      end
      MODE_HOME: begin
        q_job_o.byte_val = CMD_HOME;
        q_job_o.wait_sel = WAIT_LONG;
      end
      MODE_CURSOR: begin
        q_job_o.byte_val = CMD_SET_DDRAM | {1'b0, ddram_addr};
        keep = (in_data_i.row >= 3'd1) && (in_data_i.row <= 3'd4);
      end
      default: keep = 1'b0;
    endcase
  end

  // requests that give no pin states are taken and dropped here
  assign q_push_o = in_valid_i && !q_full_i && keep;

endmodule

[rtl/clnw_fifo.sv]
module clnw_fifo
  import clnw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  job_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CNT_W'(QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/clnw_back.sv]
module clnw_back
  import clnw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_empty_i,
  input  job_t      q_job_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  job_t              job_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              advance;
  logic [STEP_W-1:0] t;
  logic [1:0]        ph;
  logic [7:0]        cur_byte;
  logic [HOLD_W:0]   long_sum;
  logic [HOLD_W-1:0] long_hold;
  logic [HOLD_W-1:0] pulse_hold;
  logic [HOLD_W-1:0] wait_hold;
  out_item_t         nxt;

  assign advance = !out_valid_q || out_ready_i;
  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i;

  assign long_sum  = {5'd0, cfg_i.command_wait_us} + {1'b0, cfg_i.long_wait_us};
  assign long_hold = long_sum[HOLD_W] ? '1 : long_sum[HOLD_W-1:0];
  assign pulse_hold = {4'd0, cfg_i.enable_pulse_us};

  always_comb begin
    unique case (job_q.wait_sel)
      WAIT_CMD:  wait_hold = {4'd0, cfg_i.command_wait_us};
      WAIT_DATA: wait_hold = {4'd0, cfg_i.data_wait_us};
      WAIT_LONG: wait_hold = long_hold;
      default:   wait_hold = {4'd0, cfg_i.command_wait_us};
    endcase
  end

  assign t        = step_q - STEP_BYTES0;
  assign ph       = t[1:0];
  assign cur_byte = (t[3:2] == 2'd3) ? job_q.byte_val : init_byte(t[3:2]);

  always_comb begin
    nxt.reg_select = job_q.rs;
    nxt.last       = (step_q == STEP_LAST);
    if (step_q == '0) begin
      // power-up wait, all pins low
      nxt.enable  = 1'b0;
      nxt.nibble  = '0;
      nxt.hold_us = cfg_i.bootup_wait_us;
    end else if (step_q < STEP_BYTES0) begin
      // soft resets and the switch to four-bit mode
      nxt.enable = step_q[0];
      nxt.nibble = (step_q <= STEP_W'(6)) ? 4'h3 : 4'h2;
      if (step_q[0]) begin
        nxt.hold_us = pulse_hold;
      end else if (step_q == STEP_W'(2) || step_q == STEP_W'(8)) begin
        nxt.hold_us = cfg_i.reset_wait_us;
      end else begin
        nxt.hold_us = SHORT_RESET_US;
      end
    end else begin
      nxt.enable = !ph[0];
      nxt.nibble = ph[1] ? cur_byte[3:0] : cur_byte[7:4];
      if (!ph[0]) begin
        nxt.hold_us = pulse_hold;
      end else if (ph[1]) begin
        // setup bytes of an init run always close on the command wait
        nxt.hold_us = (t[3:2] == 2'd3) ? wait_hold : {4'd0, cfg_i.command_wait_us};
      end else begin
        nxt.hold_us = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      job_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            job_q   <= q_job_i;
            step_q  <= q_job_i.is_init ? '0 : STEP_BYTE;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (advance) begin
            out_valid_q <= 1'b1;
            out_q       <= nxt;
            step_q      <= step_q + 1'b1;
            if (step_q == STEP_LAST) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/clnw_checker.sv]
module clnw_checker
  import clnw_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // a waiting pin state holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // a request held by the source stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input changed while stalled");

  // a request never ends on an enable-high state
  a_last_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.enable |-> !out_data_o.last)
    else $error("last flag on enable-high state");

  // the enable-low state follows its strobe at once
  a_strobe_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.enable
    |=> out_valid_o && !out_data_o.enable)
    else $error("enable-low state missing after strobe");

endmodule

bind char_lcd_nibble_writer_core clnw_checker u_clnw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[dv/tb_char_lcd_nibble_writer_core.sv]
module tb_char_lcd_nibble_writer_core;
  import clnw_pkg::*;

  localparam int unsigned CLK_PERIOD     = 4;
  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned TIMEOUT_CYCLES = 2_000_000;
  // a dropped request gives no pin states, a byte four, an init 25
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned PHASES         = 10;
  localparam int unsigned PHASE_ITEMS    = 18;

  // codes outside the request enum and the register map
  localparam logic [2:0]           MODE_SPARE_A = 3'd6;
  localparam logic [2:0]           MODE_SPARE_B = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 4'd15;

  // controller instruction codes and init nibbles
  localparam logic [7:0]  INSTR_CLEAR   = 8'h01;
  localparam logic [7:0]  INSTR_HOME    = 8'h02;
  localparam logic [7:0]  LCD_ENTRY     = 8'h06;
  localparam logic [7:0]  LCD_DISPLAY   = 8'h0C;
  localparam logic [7:0]  LCD_FUNCTION  = 8'h28;
  localparam logic [7:0]  LCD_SET_DDRAM = 8'h80;
  localparam logic [6:0]  LCD_ROW2_BASE = 7'h40;
  localparam logic [3:0]  NIB_SOFT_RESET = 4'h3;
  localparam logic [3:0]  NIB_FOUR_BIT   = 4'h2;
  localparam logic [19:0] SOFT_RESET_GAP = 20'd1000;

  // directed row: request, then the typed expectation where there is one
  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  value;
    logic [2:0]  row;
    logic [6:0]  column;
    logic        typed;
    logic        silent;
    logic        rs;
    logic [7:0]  cmd;
    logic [19:0] wait_us;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 20;
  // typed waits assume register defaults: command 42, data 46, long hold 2042
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{MODE_INIT,    8'h00, 3'd0, 7'd0,   1'b0, 1'b0, 1'b0, 8'h00, 20'd0},
    '{MODE_COMMAND, 8'h00, 3'd0, 7'd0,   1'b1, 1'b0, 1'b0, 8'h00, 20'd42},
    '{MODE_COMMAND, 8'hFF, 3'd7, 7'd127, 1'b1, 1'b0, 1'b0, 8'hFF, 20'd42},
    '{MODE_DATA,    8'h00, 3'd0, 7'd0,   1'b1, 1'b0, 1'b1, 8'h00, 20'd46},
    '{MODE_DATA,    8'hFF, 3'd0, 7'd0,   1'b1, 1'b0, 1'b1, 8'hFF, 20'd46},
    '{MODE_DATA,    8'hA5, 3'd2, 7'd33,  1'b0, 1'b0, 1'b0, 8'h00, 20'd0},
    '{MODE_CLEAR,   8'hFF, 3'd7, 7'd127, 1'b1, 1'b0, 1'b0, 8'h01, 20'd2042},
    '{MODE_HOME,    8'h00, 3'd0, 7'd0,   1'b1, 1'b0, 1'b0, 8'h02, 20'd2042},
    '{MODE_CURSOR,  8'h00, 3'd1, 7'd0,   1'b1, 1'b0, 1'b0, 8'h80, 20'd42},
    '{MODE_CURSOR,  8'hFF, 3'd2, 7'd127, 1'b1, 1'b0, 1'b0, 8'hBF, 20'd42},
    '{MODE_CURSOR,  8'h00, 3'd3, 7'd0,   1'b1, 1'b0, 1'b0, 8'h90, 20'd42},
    '{MODE_CURSOR,  8'h00, 3'd4, 7'd127, 1'b1, 1'b0, 1'b0, 8'hCF, 20'd42},
    '{MODE_CURSOR,  8'h00, 3'd0, 7'd5,   1'b1, 1'b1, 1'b0, 8'h00, 20'd0},
    '{MODE_CURSOR,  8'h00, 3'd5, 7'd0,   1'b1, 1'b1, 1'b0, 8'h00, 20'd0},
    '{MODE_CURSOR,  8'hFF, 3'd7, 7'd127, 1'b1, 1'b1, 1'b0, 8'h00, 20'd0},
    '{MODE_SPARE_A, 8'h00, 3'd0, 7'd0,   1'b1, 1'b1, 1'b0, 8'h00, 20'd0},
    '{MODE_SPARE_B, 8'hFF, 3'd7, 7'd127, 1'b1, 1'b1, 1'b0, 8'h00, 20'd0},
    '{MODE_CURSOR,  8'h3C, 3'd3, 7'd120, 1'b0, 1'b0, 1'b0, 8'h00, 20'd0},
    '{MODE_COMMAND, 8'h5A, 3'd0, 7'd0,   1'b0, 1'b0, 1'b0, 8'h00, 20'd0},
    '{MODE_INIT,    8'hFF, 3'd7, 7'd127, 1'b0, 1'b0, 1'b0, 8'h00, 20'd0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // shadow of the register file and the pin states still owed by the block
  cfg_t      lcd_cfg;
  out_item_t pin_q[$];
  out_item_t want;
  int unsigned fail_count;
  bit burst_mode;
  bit hold_off_req;

  char_lcd_nibble_writer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void push_pin(logic rs, logic en, logic [3:0] nib, logic [19:0] hold);
    out_item_t s;
    s.reg_select = rs;
    s.enable     = en;
    s.nibble     = nib;
    s.hold_us    = hold;
    s.last       = 1'b0;
    pin_q.push_back(s);
  endfunction

  // enable high for the pulse time, then enable low with the given hold
  function automatic void strobe_nibble(logic rs, logic [3:0] nib, logic [19:0] low_hold);
    push_pin(rs, 1'b1, nib, {4'b0, lcd_cfg.enable_pulse_us});
    push_pin(rs, 1'b0, nib, low_hold);
  endfunction

  // high nibble first, no wait between the halves
  function automatic void push_byte(logic rs, logic [7:0] b, logic [19:0] wait_us);
    strobe_nibble(rs, b[7:4], '0);
    strobe_nibble(rs, b[3:0], wait_us);
  endfunction

  // command wait plus long wait, saturating at the hold width
  function automatic logic [19:0] clear_hold();
    logic [20:0] sum;
    sum = {5'b0, lcd_cfg.command_wait_us} + {1'b0, lcd_cfg.long_wait_us};
    return sum[20] ? {HOLD_W{1'b1}} : sum[19:0];
  endfunction

  function automatic void mark_last(int unsigned base);
    out_item_t s;
    if (pin_q.size() > base) begin
      s = pin_q.pop_back();
      s.last = 1'b1;
      pin_q.push_back(s);
    end
  endfunction

  // expands one request into its pin states, returns how many
  function automatic int unsigned expand_request(in_item_t req);
    int unsigned base;
    logic [6:0]  start;
    logic [6:0]  addr;
    logic        row_ok;
    base = pin_q.size();
    case (req.mode)
      MODE_INIT: begin
        push_pin(1'b0, 1'b0, 4'h0, lcd_cfg.bootup_wait_us);
        strobe_nibble(1'b0, NIB_SOFT_RESET, lcd_cfg.reset_wait_us);
        strobe_nibble(1'b0, NIB_SOFT_RESET, SOFT_RESET_GAP);
        strobe_nibble(1'b0, NIB_SOFT_RESET, SOFT_RESET_GAP);
        strobe_nibble(1'b0, NIB_FOUR_BIT, lcd_cfg.reset_wait_us);
        push_byte(1'b0, LCD_FUNCTION, {4'b0, lcd_cfg.command_wait_us});
        push_byte(1'b0, LCD_DISPLAY, {4'b0, lcd_cfg.command_wait_us});
        push_byte(1'b0, LCD_ENTRY, {4'b0, lcd_cfg.command_wait_us});
        push_byte(1'b0, INSTR_CLEAR, clear_hold());
      end
      MODE_COMMAND: push_byte(1'b0, req.value, {4'b0, lcd_cfg.command_wait_us});
      MODE_DATA:    push_byte(1'b1, req.value, {4'b0, lcd_cfg.data_wait_us});
      MODE_CLEAR:   push_byte(1'b0, INSTR_CLEAR, clear_hold());
      MODE_HOME:    push_byte(1'b0, INSTR_HOME, clear_hold());
      MODE_CURSOR: begin
        row_ok = 1'b1;
        start  = '0;
        case (req.row)
          3'd1:    start = 7'h00;
          3'd2:    start = LCD_ROW2_BASE;
          3'd3:    start = lcd_cfg.line3_address;
          3'd4:    start = lcd_cfg.line4_address;
          default: row_ok = 1'b0;
        endcase
        // ddram address wraps at 128
        addr = start + req.column;
        if (row_ok) push_byte(1'b0, LCD_SET_DDRAM | {1'b0, addr},
                              {4'b0, lcd_cfg.command_wait_us});
      end
      default: ;
    endcase
    mark_last(base);
    return pin_q.size() - base;
  endfunction

  // ---------------------------------------------------------------- helpers

  // mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 40);
  endfunction

  // called at a falling edge, returns at the rising edge that takes the transaction
  task automatic offer(in_item_t req);
    int unsigned gap;
    gap = burst_mode ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // one register write, with the enable dropped again afterwards before the task returns
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_LINE3_ADDR:  lcd_cfg.line3_address   = data[6:0];
      CFG_LINE4_ADDR:  lcd_cfg.line4_address   = data[6:0];
      CFG_EN_PULSE:    lcd_cfg.enable_pulse_us = data[15:0];
      CFG_CMD_WAIT:    lcd_cfg.command_wait_us = data[15:0];
      CFG_DATA_WAIT:   lcd_cfg.data_wait_us    = data[15:0];
      CFG_LONG_WAIT:   lcd_cfg.long_wait_us    = data;
      CFG_BOOTUP_WAIT: lcd_cfg.bootup_wait_us  = data;
      CFG_RESET_WAIT:  lcd_cfg.reset_wait_us   = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // all owed pin states out, then a margin for dropped requests still inside
  task automatic wait_idle();
    while (pin_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    int unsigned stall;
    stall       = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        // long hold-off so the queue fills and the input stalls
        hold_off_req = 1'b0;
        stall        = HOLD_OFF_CYCLES;
      end else if (stall == 0 && !burst_mode) begin
        stall = pick_gap();
      end
      out_ready_i <= (stall == 0);
      if (stall != 0) stall--;
    end
  end

  // compare every accepted pin state with the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pin_q.size() == 0) begin
        $error("pin state with nothing owed: %p", out_data_o);
        fail_count++;
      end else begin
        want = pin_q.pop_front();
        if (out_data_o.reg_select !== want.reg_select) begin
          $error("reg_select: expected %0d, got %0d", want.reg_select, out_data_o.reg_select);
          fail_count++;
        end
        if (out_data_o.enable !== want.enable) begin
          $error("enable: expected %0d, got %0d", want.enable, out_data_o.enable);
          fail_count++;
        end
        if (out_data_o.nibble !== want.nibble) begin
          $error("nibble: expected %0h, got %0h", want.nibble, out_data_o.nibble);
          fail_count++;
        end
        if (out_data_o.hold_us !== want.hold_us) begin
          $error("hold_us: expected %0d, got %0d", want.hold_us, out_data_o.hold_us);
          fail_count++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data_o.last);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    in_item_t                req;
    logic [CFG_DATA_W-1:0]   word;
    int unsigned             base;
    int unsigned             counted;
    int unsigned             pick;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    fail_count   = 0;
    burst_mode   = 1'b0;
    hold_off_req = 1'b0;
    lcd_cfg      = CFG_RESET;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table at register defaults
    for (int i = 0; i < DIR_ROWS; i++) begin
      req.mode   = DIRECTED[i].mode;
      req.value  = DIRECTED[i].value;
      req.row    = DIRECTED[i].row;
      req.column = DIRECTED[i].column;
      offer(req);
      if (DIRECTED[i].typed) begin
        base = pin_q.size();
        if (!DIRECTED[i].silent)
          push_byte(DIRECTED[i].rs, DIRECTED[i].cmd, DIRECTED[i].wait_us);
        mark_last(base);
      end else begin
        void'(expand_request(req));
      end
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;

    // random phases: all-ones registers, all-zero registers, then random settings
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      for (int r = 0; r < 8; r++) begin
        if (ph == 0) word = '1;
        else if (ph == 1) word = '0;
        else begin
          pick = $urandom_range(0, 9);
          if (pick == 0) word = '0;
          else if (pick == 1) word = '1;
          else word = CFG_DATA_W'($urandom);
        end
        write_reg(cfg_idx_e'(r), word);
      end
      if (ph == 1) begin
        // writes beyond the register map must leave everything alone
        write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_HI, '1);
      end
      burst_mode = (ph == 5);
      if (ph == 3) hold_off_req = 1'b1;

      counted = 0;
      while (counted < PHASE_ITEMS) begin
        req.value  = 8'($urandom);
        req.row    = 3'($urandom);
        req.column = 7'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 5)       req.mode = MODE_INIT;
        else if (pick < 25) req.mode = MODE_COMMAND;
        else if (pick < 50) req.mode = MODE_DATA;
        else if (pick < 57) req.mode = MODE_CLEAR;
        else if (pick < 64) req.mode = MODE_HOME;
        else if (pick < 92) begin
          req.mode = MODE_CURSOR;
          // mostly valid rows, the rest fall through to nothing
          if ($urandom_range(0, 99) < 85) req.row = 3'($urandom_range(1, 4));
        end else begin
          req.mode = 3'($urandom_range(MODE_SPARE_A, MODE_SPARE_B));
        end
        offer(req);
        if (expand_request(req) != 0) counted++;
        @(negedge clk_i);
      end
      in_valid_i <= 1'b0;
    end
    burst_mode = 1'b0;

    wait_idle();
    if (fail_count == 0 && pin_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
